### design/jchl_pkg.sv
// Shared types and constants for the canonical Huffman lookup unit.
package jchl_pkg;

	localparam int unsigned MAX_CODE_LENGTH_DEF = 16;
	localparam int unsigned SYMBOL_DEPTH_DEF    = 256;

	localparam int unsigned LEN_W   = 5;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned SYM_W   = 8;
	localparam int unsigned BITS_W  = 16;
	localparam int unsigned CODE_W  = 17;
	localparam int unsigned IDX_W   = 10;

	localparam logic [SYM_W-1:0] EOB_SYMBOL = 8'h00;

	typedef enum logic [1:0] {
		CMD_CLEAR       = 2'd0,
		CMD_LOAD_COUNT  = 2'd1,
		CMD_LOAD_SYMBOL = 2'd2,
		CMD_LOOKUP      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_ADDR,
		ST_READ
	} state_t;

	typedef struct packed {
		logic clear;
		logic load_count;
		logic load_symbol;
		logic capture;
		logic calc;
		logic addr;
		logic out_load;
	} ctrl_t;

endpackage

### design/jchl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jchl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/jchl_ctrl.sv
// Controller state machine: sequences commands and the lookup steps, owns output valid.
module jchl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       command,
	output logic             out_valid,
	input  logic             out_ready,
	output jchl_pkg::ctrl_t  ctrl
);

	jchl_pkg::state_t state_q, state_d;
	logic             out_valid_q, out_valid_d;
	logic             accept;
	jchl_pkg::cmd_t   cmd;

	assign cmd = jchl_pkg::cmd_t'(command);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jchl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		accept   = 1'b0;
		unique case (state_q)
			jchl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (accept) begin
					unique case (cmd)
						jchl_pkg::CMD_CLEAR:       ctrl.clear       = 1'b1;
						jchl_pkg::CMD_LOAD_COUNT:  ctrl.load_count  = 1'b1;
						jchl_pkg::CMD_LOAD_SYMBOL: ctrl.load_symbol = 1'b1;
						jchl_pkg::CMD_LOOKUP: begin
							ctrl.capture = 1'b1;
							state_d      = jchl_pkg::ST_CALC;
						end
					endcase
				end
			end
			jchl_pkg::ST_CALC: begin
				ctrl.calc = 1'b1;
				state_d   = jchl_pkg::ST_ADDR;
			end
			jchl_pkg::ST_ADDR: begin
				ctrl.addr = 1'b1;
				state_d   = jchl_pkg::ST_READ;
			end
			jchl_pkg::ST_READ: begin
				// hold the read word until the output register is free
				if (!out_valid_q || out_ready) begin
					ctrl.out_load = 1'b1;
					state_d       = jchl_pkg::ST_IDLE;
				end
			end
			default: state_d = jchl_pkg::ST_IDLE;
		endcase
		out_valid_d = ctrl.out_load | (out_valid_q & ~out_ready);
	end

	assign out_valid = out_valid_q;

endmodule

### design/jchl_datapath.sv
// Datapath: per-length code tables, symbol store and the lookup compare chain.
module jchl_datapath #(
	parameter int unsigned MAX_CODE_LENGTH = jchl_pkg::MAX_CODE_LENGTH_DEF,
	parameter int unsigned SYMBOL_DEPTH    = jchl_pkg::SYMBOL_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  jchl_pkg::ctrl_t                ctrl,
	input  logic [jchl_pkg::LEN_W-1:0]     code_length,
	input  logic [jchl_pkg::COUNT_W-1:0]   symbol_count,
	input  logic [jchl_pkg::SYM_W-1:0]     symbol_value,
	input  logic [jchl_pkg::BITS_W-1:0]    code_bits,
	output logic                           hit,
	output logic [jchl_pkg::SYM_W-1:0]     symbol,
	output logic                           end_of_block
);

	localparam int unsigned SLOT_W = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
	localparam int unsigned ADDR_W = $clog2(SYMBOL_DEPTH);
	localparam int unsigned PTR_W  = $clog2(SYMBOL_DEPTH + 1);
	localparam int unsigned LEN_W  = jchl_pkg::LEN_W;
	localparam int unsigned CNT_W  = jchl_pkg::COUNT_W;
	localparam int unsigned CODE_W = jchl_pkg::CODE_W;
	localparam int unsigned IDX_W  = jchl_pkg::IDX_W;
	localparam int unsigned SYM_W  = jchl_pkg::SYM_W;

	// table state
	logic [CNT_W-1:0]  length_count_q  [MAX_CODE_LENGTH];
	logic [CODE_W-1:0] first_code_q    [MAX_CODE_LENGTH];
	logic [CNT_W-1:0]  symbol_offset_q [MAX_CODE_LENGTH];
	logic [CODE_W-1:0] next_code_q;
	logic [PTR_W-1:0]  write_pointer_q;
	logic [LEN_W-1:0]  expected_length_q;
	logic [CNT_W-1:0]  symbol_total_q;

	// load count
	logic              load_ok;
	logic [SLOT_W-1:0] load_slot;
	logic [CODE_W-1:0] shifted_code;
	logic [CNT_W:0]    total_sum;
	logic              store_ok;

	// lookup pipeline
	logic [LEN_W-1:0]         len_q;
	logic [jchl_pkg::BITS_W-1:0] bits_q;
	logic              len_ok;
	logic [SLOT_W-1:0] look_slot;
	logic [CODE_W-1:0] code_mask;
	logic [CODE_W-1:0] code;
	logic [CODE_W-1:0] diff;
	logic              range_ok;
	logic              in_range_s1;
	logic [CNT_W-1:0]  diff_s1;
	logic [CNT_W-1:0]  offset_s1;
	logic [IDX_W-1:0]  idx;
	logic              hit_s2;
	logic [SYM_W-1:0]  ram_rd_data;
	logic              hit_q;
	logic [SYM_W-1:0]  symbol_q;

	assign load_ok = (code_length != '0) && (code_length <= LEN_W'(MAX_CODE_LENGTH))
		&& (code_length >= expected_length_q);
	assign load_slot    = SLOT_W'(code_length - LEN_W'(1));
	assign shifted_code = next_code_q << (code_length - expected_length_q);
	assign total_sum    = {1'b0, symbol_total_q} + {1'b0, symbol_count};
	assign store_ok     = write_pointer_q < PTR_W'(SYMBOL_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
				length_count_q[i]  <= '0;
				first_code_q[i]    <= '0;
				symbol_offset_q[i] <= '0;
			end
			next_code_q       <= '0;
			write_pointer_q   <= '0;
			expected_length_q <= LEN_W'(1);
			symbol_total_q    <= '0;
		end else if (ctrl.clear) begin
			for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
				length_count_q[i]  <= '0;
				first_code_q[i]    <= '0;
				symbol_offset_q[i] <= '0;
			end
			next_code_q       <= '0;
			write_pointer_q   <= '0;
			expected_length_q <= LEN_W'(1);
			symbol_total_q    <= '0;
		end else begin
			if (ctrl.load_count && load_ok) begin
				first_code_q[load_slot]    <= shifted_code;
				symbol_offset_q[load_slot] <= symbol_total_q;
				length_count_q[load_slot]  <= symbol_count;
				next_code_q       <= (shifted_code + CODE_W'(symbol_count)) << 1;
				expected_length_q <= code_length + LEN_W'(1);
				// saturate the running total
				symbol_total_q    <= total_sum[CNT_W] ? '1 : total_sum[CNT_W-1:0];
			end
			if (ctrl.load_symbol && store_ok) begin
				write_pointer_q <= write_pointer_q + PTR_W'(1);
			end
		end
	end

	// lookup: capture the word, then range check, then index and read
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			len_q  <= code_length;
			bits_q <= code_bits;
		end
	end

	assign len_ok    = (len_q != '0) && (len_q <= LEN_W'(MAX_CODE_LENGTH));
	assign look_slot = SLOT_W'(len_q - LEN_W'(1));
	assign code_mask = (CODE_W'(1) << len_q) - CODE_W'(1);
	assign code      = CODE_W'(bits_q) & code_mask;
	assign diff      = code - first_code_q[look_slot];
	assign range_ok  = len_ok && (code >= first_code_q[look_slot])
		&& (diff < CODE_W'(length_count_q[look_slot]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_range_s1 <= 1'b0;
			hit_s2      <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			if (ctrl.calc) begin
				in_range_s1 <= range_ok;
			end
			if (ctrl.addr) begin
				hit_s2 <= in_range_s1 && (idx < IDX_W'(write_pointer_q));
			end
			if (ctrl.out_load) begin
				hit_q <= hit_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.calc) begin
			diff_s1   <= diff[CNT_W-1:0];
			offset_s1 <= symbol_offset_q[look_slot];
		end
		if (ctrl.out_load) begin
			symbol_q <= hit_s2 ? ram_rd_data : '0;
		end
	end

	assign idx = IDX_W'(offset_s1) + IDX_W'(diff_s1);

	jchl_ram #(
		.WIDTH (SYM_W),
		.DEPTH (SYMBOL_DEPTH)
	) u_symbol_store (
		.clk     (clk),
		.wr_en   (ctrl.load_symbol && store_ok),
		.wr_addr (write_pointer_q[ADDR_W-1:0]),
		.wr_data (symbol_value),
		.rd_en   (ctrl.addr),
		.rd_addr (idx[ADDR_W-1:0]),
		.rd_data (ram_rd_data)
	);

	assign hit          = hit_q;
	assign symbol       = symbol_q;
	assign end_of_block = hit_q && (symbol_q == jchl_pkg::EOB_SYMBOL);

endmodule

### design/jpeg_canonical_huffman_lookup_unit.sv
// Top level of the canonical Huffman table builder and code lookup unit.
//
// Input channel (in_valid/in_ready) carries one command word: clear table,
// load the symbol count of one code length (lengths in ascending order),
// load the next symbol, or look up a code given with its exact length.
// Only a lookup produces an output word on the out_valid/out_ready channel:
// hit, the symbol (zero on a miss) and end_of_block for symbol zero.
// Clear and load words act at acceptance; a new word is taken the next
// cycle. A lookup is captured at acceptance and passes through registered
// steps: range check against the first code and count of its length,
// symbol index and registered store read, output register load. One
// lookup is in flight at a time; no new word is taken until it has loaded
// the output register.
// The output register lets a new word be accepted while a result waits. If
// the receiver stalls, a following lookup holds in its last step until the
// output register frees; ready stays low meanwhile.
// Reset empties the table (no counts, no symbols loaded) and clears output
// valid. Symbol store contents are not cleared; unloaded entries are never hit.
module jpeg_canonical_huffman_lookup_unit #(
	parameter int unsigned MAX_CODE_LENGTH = jchl_pkg::MAX_CODE_LENGTH_DEF,
	parameter int unsigned SYMBOL_DEPTH    = jchl_pkg::SYMBOL_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     command,
	input  logic [jchl_pkg::LEN_W-1:0]     code_length,
	input  logic [jchl_pkg::COUNT_W-1:0]   symbol_count,
	input  logic [jchl_pkg::SYM_W-1:0]     symbol_value,
	input  logic [jchl_pkg::BITS_W-1:0]    code_bits,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [jchl_pkg::SYM_W-1:0]     symbol,
	output logic                           end_of_block
);

	jchl_pkg::ctrl_t ctrl;

	jchl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	jchl_datapath #(
		.MAX_CODE_LENGTH (MAX_CODE_LENGTH),
		.SYMBOL_DEPTH    (SYMBOL_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.code_length  (code_length),
		.symbol_count (symbol_count),
		.symbol_value (symbol_value),
		.code_bits    (code_bits),
		.hit          (hit),
		.symbol       (symbol),
		.end_of_block (end_of_block)
	);

endmodule

### tb/jpeg_canonical_huffman_lookup_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the canonical Huffman table builder and code lookup unit.
module jpeg_canonical_huffman_lookup_unit_test;

	localparam int unsigned MAX_LEN      = jchl_pkg::MAX_CODE_LENGTH_DEF;
	localparam int unsigned DEPTH        = jchl_pkg::SYMBOL_DEPTH_DEF;
	localparam int unsigned LEN_W        = jchl_pkg::LEN_W;
	localparam int unsigned COUNT_W      = jchl_pkg::COUNT_W;
	localparam int unsigned SYM_W        = jchl_pkg::SYM_W;
	localparam int unsigned BITS_W       = jchl_pkg::BITS_W;
	localparam int unsigned CODE_W       = jchl_pkg::CODE_W;
	localparam int unsigned RANDOM_WORDS = 1000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef struct packed {
		jchl_pkg::cmd_t     command;
		logic [LEN_W-1:0]   code_length;
		logic [COUNT_W-1:0] symbol_count;
		logic [SYM_W-1:0]   symbol_value;
		logic [BITS_W-1:0]  code_bits;
	} word_t;

	typedef struct packed {
		logic             hit;
		logic [SYM_W-1:0] symbol;
		logic             end_of_block;
	} decode_t;

	typedef struct packed {
		logic [15:0][COUNT_W-1:0] length_count;
		logic [15:0][CODE_W-1:0]  first_code;
		logic [15:0][COUNT_W-1:0] symbol_offset;
		logic [CODE_W-1:0]        next_code;
		logic [255:0][SYM_W-1:0]  symbols;
		logic [COUNT_W-1:0]       wr_ptr;
		logic [LEN_W-1:0]         min_length;
		logic [COUNT_W-1:0]       symbol_total;
	} huff_table_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic [1:0]         command      = 2'b0;
	logic [LEN_W-1:0]   code_length  = '0;
	logic [COUNT_W-1:0] symbol_count = '0;
	logic [SYM_W-1:0]   symbol_value = '0;
	logic [BITS_W-1:0]  code_bits    = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic               hit;
	logic [SYM_W-1:0]   symbol;
	logic               end_of_block;

	word_t       pending_words[$];
	decode_t     expected_decodes[$];
	huff_table_t gen_table;
	huff_table_t dut_table;

	int unsigned queued      = 0;
	int unsigned sent        = 0;
	int unsigned taken       = 0;
	int unsigned hold_left   = 0;
	bit          held        = 1'b0;
	int unsigned words_seen  = 0;
	int unsigned lookups     = 0;
	int unsigned hits        = 0;
	int unsigned eobs        = 0;
	int unsigned idle_cycles = 0;
	int unsigned mismatches  = 0;

	jpeg_canonical_huffman_lookup_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.code_length  (code_length),
		.symbol_count (symbol_count),
		.symbol_value (symbol_value),
		.code_bits    (code_bits),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.symbol       (symbol),
		.end_of_block (end_of_block)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic huff_table_t advance_table(huff_table_t t, word_t w);
		int unsigned slot;
		int unsigned sum;
		case (w.command)
			jchl_pkg::CMD_CLEAR: begin
				// symbol store contents survive a clear
				t.length_count  = '0;
				t.first_code    = '0;
				t.symbol_offset = '0;
				t.next_code     = '0;
				t.wr_ptr        = '0;
				t.min_length    = LEN_W'(1);
				t.symbol_total  = '0;
			end
			jchl_pkg::CMD_LOAD_COUNT: begin
				if (w.code_length != 0 && w.code_length <= MAX_LEN &&
						w.code_length >= t.min_length) begin
					slot = w.code_length - 1;
					t.next_code = t.next_code << (w.code_length - t.min_length);
					t.first_code[slot]    = t.next_code;
					t.symbol_offset[slot] = t.symbol_total;
					t.length_count[slot]  = w.symbol_count;
					t.next_code  = (t.next_code + CODE_W'(w.symbol_count)) << 1;
					t.min_length = w.code_length + LEN_W'(1);
					sum = t.symbol_total + w.symbol_count;
					t.symbol_total = (sum > 511) ? 9'd511 : sum[COUNT_W-1:0];
				end
			end
			jchl_pkg::CMD_LOAD_SYMBOL: begin
				if (t.wr_ptr < DEPTH) begin
					t.symbols[t.wr_ptr[7:0]] = w.symbol_value;
					t.wr_ptr = t.wr_ptr + COUNT_W'(1);
				end
			end
			default: ;
		endcase
		return t;
	endfunction

	function automatic decode_t decode_table(huff_table_t t, logic [LEN_W-1:0] len,
			logic [BITS_W-1:0] bits);
		decode_t     r;
		int unsigned slot;
		int unsigned code;
		int unsigned diff;
		int unsigned idx;
		r = '0;
		if (len == 0 || len > MAX_LEN)
			return r;
		slot = len - 1;
		// drop code bits above the given length
		code = bits & ((32'd1 << len) - 32'd1);
		if (code < t.first_code[slot])
			return r;
		diff = code - t.first_code[slot];
		if (diff >= t.length_count[slot])
			return r;
		idx = t.symbol_offset[slot] + diff;
		if (idx >= t.wr_ptr || idx >= DEPTH)
			return r;
		r.hit          = 1'b1;
		r.symbol       = t.symbols[idx[7:0]];
		r.end_of_block = (t.symbols[idx[7:0]] == jchl_pkg::EOB_SYMBOL);
		return r;
	endfunction

	// Unused fields carry random junk; the block must ignore them.
	task automatic queue_op(jchl_pkg::cmd_t c, int unsigned len, int unsigned num,
			int unsigned bits);
		word_t       w;
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		w = junk[$bits(word_t)-1:0];
		w.command = c;
		case (c)
			jchl_pkg::CMD_LOAD_COUNT: begin
				w.code_length  = LEN_W'(len);
				w.symbol_count = COUNT_W'(num);
			end
			jchl_pkg::CMD_LOAD_SYMBOL: w.symbol_value = SYM_W'(num);
			jchl_pkg::CMD_LOOKUP: begin
				w.code_length = LEN_W'(len);
				w.code_bits   = BITS_W'(bits);
			end
			default: ;
		endcase
		pending_words.push_back(w);
		gen_table = advance_table(gen_table, w);
		queued++;
	endtask

	// Aim a lookup at an assigned code of the table built so far, junk above its length.
	task automatic queue_assigned_lookup();
		int unsigned len;
		int unsigned diff;
		int unsigned code;
		int unsigned mask;
		len = $urandom_range(1, MAX_LEN);
		for (int i = 0; i < 16 && gen_table.length_count[len-1] == 0; i++)
			len = $urandom_range(1, MAX_LEN);
		diff = (gen_table.length_count[len-1] == 0) ? 0 :
			$urandom_range(0, gen_table.length_count[len-1] - 1);
		code = gen_table.first_code[len-1] + diff;
		mask = (32'd1 << len) - 32'd1;
		queue_op(jchl_pkg::CMD_LOOKUP, len, 0, (code & mask) | ($urandom & ~mask));
	endtask

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin : driver
		word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				sent++;
			// no idling on the sender for a stretch in the middle of the run
			if (pending_words.size() != 0 &&
					(($urandom_range(0, 99) >= 8) || (sent >= 300 && sent < 550))) begin
				w = pending_words.pop_front();
				in_valid     <= 1'b1;
				command      <= w.command;
				code_length  <= w.code_length;
				symbol_count <= w.symbol_count;
				symbol_value <= w.symbol_value;
				code_bits    <= w.code_bits;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : receiver
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				taken++;
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!held && taken == 40) begin
				// hold off long enough for the block to back up into its input
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (taken >= 200 && taken < 350) || ($urandom_range(0, 99) >= 8);
			end
		end
	end

	always @(posedge clk) begin : monitor
		word_t   w;
		decode_t want;
		bit      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && in_ready) begin
				moved = 1'b1;
				w = {command, code_length, symbol_count, symbol_value, code_bits};
				if (w.command == jchl_pkg::CMD_LOOKUP) begin
					expected_decodes.push_back(decode_table(dut_table, w.code_length,
						w.code_bits));
					lookups++;
				end
				dut_table = advance_table(dut_table, w);
				words_seen++;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (expected_decodes.size() == 0) begin
					report_mismatch($sformatf("unexpected word hit %0d symbol %h eob %0d",
						hit, symbol, end_of_block));
				end else begin
					want = expected_decodes.pop_front();
					if (hit !== want.hit || symbol !== want.symbol ||
							end_of_block !== want.end_of_block)
						report_mismatch($sformatf(
							"expected hit %0d symbol %h eob %0d, got hit %0d symbol %h eob %0d",
							want.hit, want.symbol, want.end_of_block,
							hit, symbol, end_of_block));
					if (want.hit)
						hits++;
					if (want.end_of_block)
						eobs++;
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("no word moved for %0d cycles, %0d results outstanding",
					idle_cycles, expected_decodes.size());
				$display("FAIL jpeg_canonical_huffman_lookup_unit");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned target;
		int unsigned loaded;
		int unsigned base;
		int unsigned avail;
		int unsigned cnt;
		int unsigned session;
		int unsigned first_random;
		int          n;

		gen_table            = '0;
		gen_table.min_length = LEN_W'(1);
		dut_table            = gen_table;

		queue_op(jchl_pkg::CMD_CLEAR, 0, 0, 0);
		queue_op(jchl_pkg::CMD_LOOKUP, 1, 0, 0);           // empty table
		queue_op(jchl_pkg::CMD_LOAD_COUNT, 0, 5, 0);       // empty length, ignored
		queue_op(jchl_pkg::CMD_LOAD_COUNT, 2, 1, 0);       // skip length 1
		queue_op(jchl_pkg::CMD_LOAD_COUNT, 1, 1, 0);       // out of order, ignored
		queue_op(jchl_pkg::CMD_LOAD_COUNT, 3, 2, 0);
		queue_op(jchl_pkg::CMD_LOAD_COUNT, 17, 3, 0);      // past the longest length, ignored
		queue_op(jchl_pkg::CMD_LOAD_COUNT, MAX_LEN, 256, 0);
		queue_op(jchl_pkg::CMD_LOAD_SYMBOL, 0, jchl_pkg::EOB_SYMBOL, 0);
		queue_op(jchl_pkg::CMD_LOAD_SYMBOL, 0, 8'hFF, 0);
		queue_op(jchl_pkg::CMD_LOAD_SYMBOL, 0, 8'h5A, 0);
		queue_op(jchl_pkg::CMD_LOAD_SYMBOL, 0, 8'hA5, 0);
		queue_op(jchl_pkg::CMD_LOOKUP, 2, 0, 16'hFFFC);    // end of block, high bits set
		queue_op(jchl_pkg::CMD_LOOKUP, 3, 0, 16'h0002);
		queue_op(jchl_pkg::CMD_LOOKUP, 3, 0, 16'h0003);
		queue_op(jchl_pkg::CMD_LOOKUP, 3, 0, 16'h0004);    // past the assigned range
		queue_op(jchl_pkg::CMD_LOOKUP, 3, 0, 16'h0001);    // below the first code
		queue_op(jchl_pkg::CMD_LOOKUP, MAX_LEN, 0, 16'h8000);
		queue_op(jchl_pkg::CMD_LOOKUP, MAX_LEN, 0, 16'h8001); // assigned, symbol not loaded
		queue_op(jchl_pkg::CMD_LOOKUP, MAX_LEN, 0, 16'hFFFF);
		queue_op(jchl_pkg::CMD_LOOKUP, 0, 0, 16'hFFFF);
		queue_op(jchl_pkg::CMD_LOOKUP, 31, 0, 16'hFFFF);
		queue_op(jchl_pkg::CMD_LOOKUP, MAX_LEN, 0, 16'h0000);

		first_random = queued;
		for (session = 0; queued - first_random < RANDOM_WORDS; session++) begin
			if (session == 2) begin
				// fill the store and push past its end
				queue_op(jchl_pkg::CMD_CLEAR, 0, 0, 0);
				queue_op(jchl_pkg::CMD_LOAD_COUNT, $urandom_range(8, MAX_LEN), DEPTH, 0);
				repeat (DEPTH + 4)
					queue_op(jchl_pkg::CMD_LOAD_SYMBOL, 0, $urandom_range(0, 255), 0);
			end else begin
				if ($urandom_range(0, 9) != 0)
					queue_op(jchl_pkg::CMD_CLEAR, 0, 0, 0);
				target = $urandom_range(1, 24);
				loaded = 0;
				for (int len = 1; len <= MAX_LEN && loaded < target; len++) begin
					if ($urandom_range(0, 7) == 0)
						queue_op(jchl_pkg::CMD_LOAD_COUNT, $urandom_range(0, 31),
							$urandom_range(0, 511), 0);
					if (len < gen_table.min_length || $urandom_range(0, 2) == 0)
						continue;
					// keep the table within the code space of this length
					base  = gen_table.next_code << (len - gen_table.min_length);
					avail = (base < (32'd1 << len)) ? (32'd1 << len) - base : 0;
					cnt   = avail;
					if (cnt > target - loaded)
						cnt = target - loaded;
					if (cnt > 8)
						cnt = 8;
					cnt = $urandom_range(0, cnt);
					queue_op(jchl_pkg::CMD_LOAD_COUNT, len, cnt, 0);
					loaded += cnt;
				end
				n = int'(gen_table.symbol_total) - int'(gen_table.wr_ptr);
				case ($urandom_range(0, 4))
					0: n = n - int'($urandom_range(1, 3));
					1: n = n + 2;
					default: ;
				endcase
				if (n < 0)
					n = 0;
				repeat (n)
					queue_op(jchl_pkg::CMD_LOAD_SYMBOL, 0,
						($urandom_range(0, 7) == 0) ? jchl_pkg::EOB_SYMBOL :
						$urandom_range(0, 255), 0);
			end
			repeat ($urandom_range(10, 40)) begin
				case ($urandom_range(0, 9))
					0: queue_op(jchl_pkg::cmd_t'(2'($urandom_range(0, 3))),
						$urandom_range(0, 31), $urandom_range(0, 511), $urandom);
					1: queue_op(jchl_pkg::CMD_LOOKUP, $urandom_range(0, 31), 0, $urandom);
					default: queue_assigned_lookup();
				endcase
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid || expected_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d words: %0d lookups, %0d hits, %0d end-of-block symbols",
			words_seen, lookups, hits, eobs);
		$display("store overflow and a %0d cycle receiver hold-off exercised, %0d mismatches",
			HOLD_CYCLES, mismatches);
		if (mismatches == 0 && expected_decodes.size() == 0) begin
			$display("PASS jpeg_canonical_huffman_lookup_unit");
		end else begin
			$display("FAIL jpeg_canonical_huffman_lookup_unit");
		end
		$finish;
	end

endmodule
